### hw/rtl/ngf_pkg.sv
// Shared types and fixed constants for the n-gram frequency table.
// No dependencies; the other files of the block, all but ngf_ram, refer to it by scoped names.
package ngf_pkg;

	localparam int TOKEN_W    = 64;
	localparam int CFG_W      = 3;
	localparam int IDX_OUT_W  = 8;
	localparam int COUNT_W    = 16;
	localparam int USED_OUT_W = 9;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;
	localparam logic [COUNT_W-1:0] COUNT_ONE   = 16'd1;
	localparam logic [CFG_W-1:0]   ORDER_RESET = 3'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} win_ctl_t;

endpackage

### hw/rtl/ngf_if.sv
// Valid/ready channel interfaces for token words in and result words out.
// Depends on ngf_pkg for the field widths.
interface ngf_in_if;
	logic                        valid;
	logic                        ready;
	logic [ngf_pkg::TOKEN_W-1:0] token_key;
	logic                        last_token;

	modport source (output valid, output token_key, output last_token, input ready);
	modport sink   (input valid, input token_key, input last_token, output ready);
endinterface

interface ngf_out_if;
	logic                           valid;
	logic                           ready;
	logic                           ngram_formed;
	logic [ngf_pkg::IDX_OUT_W-1:0]  entry_index;
	logic [ngf_pkg::COUNT_W-1:0]    entry_count;
	logic                           was_inserted;
	logic                           table_overflow;
	logic [ngf_pkg::USED_OUT_W-1:0] entries_in_use;

	modport source (output valid, output ngram_formed, output entry_index,
		output entry_count, output was_inserted, output table_overflow,
		output entries_in_use, input ready);
	modport sink   (input valid, input ngram_formed, input entry_index,
		input entry_count, input was_inserted, input table_overflow,
		input entries_in_use, output ready);
endinterface

### hw/rtl/ngf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ngf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/ngf_window.sv
// Window of previous tokens and assembly of the n-gram closed by the current token.
// Depends on ngf_pkg.
module ngf_window #(
	parameter int MAX_ORDER = 4,
	parameter int KEY_W     = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ngf_pkg::win_ctl_t                ctl,
	input  logic [ngf_pkg::CFG_W-1:0]        cfg_order,
	input  logic [KEY_W-1:0]                 key,
	output logic [$clog2(MAX_ORDER+1)-1:0]   eff_order,
	output logic                             formed,
	output logic [MAX_ORDER*KEY_W-1:0]       gram
);

	localparam int ORD_W  = $clog2(MAX_ORDER + 1);
	localparam int RDEPTH = (MAX_ORDER > 1) ? MAX_ORDER - 1 : 1;

	logic [KEY_W-1:0] recent_q [RDEPTH];
	logic [ORD_W-1:0] fill_q;

	always_comb begin
		if (cfg_order == '0) begin
			eff_order = ORD_W'(1);
		end else if (int'(cfg_order) > MAX_ORDER) begin
			eff_order = ORD_W'(MAX_ORDER);
		end else begin
			eff_order = ORD_W'(cfg_order);
		end
	end

	assign formed = ({1'b0, fill_q} + {{ORD_W{1'b0}}, 1'b1}) >= {1'b0, eff_order};

	always_comb begin
		gram = '0;
		for (int k = 0; k < MAX_ORDER; k++) begin
			if (k + 1 == int'(eff_order)) begin
				gram[k*KEY_W +: KEY_W] = key;
			end else if (k + 1 < int'(eff_order)) begin
				for (int j = 0; j < RDEPTH; j++) begin
					if (j + k + 2 == int'(eff_order)) begin
						gram[k*KEY_W +: KEY_W] = recent_q[j];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			recent_q[0] <= key;
			for (int i = 1; i < RDEPTH; i++) begin
				recent_q[i] <= recent_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctl.clear) begin
			fill_q <= '0;
		end else if (ctl.shift && int'(fill_q) < MAX_ORDER - 1) begin
			fill_q <= fill_q + ORD_W'(1);
		end
	end

endmodule

### hw/rtl/ngf_scan.sv
// Sequencer: first-match scan of the key memory, count update or append, result register.
// Depends on ngf_pkg and the channel interfaces in ngf_if.
module ngf_scan #(
	parameter int TABLE_DEPTH = 256,
	parameter int MAX_ORDER   = 4,
	parameter int KEY_W       = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	ngf_in_if.sink                             tok,
	ngf_out_if.source                          res,
	input  logic [$clog2(MAX_ORDER+1)-1:0]     eff_order,
	input  logic                               formed,
	input  logic [MAX_ORDER*KEY_W-1:0]         gram,
	output ngf_pkg::win_ctl_t                  win_ctl,
	output logic                               key_re,
	output logic [$clog2(TABLE_DEPTH)-1:0]     key_raddr,
	input  logic [MAX_ORDER*KEY_W-1:0]         key_rdata,
	output logic                               key_we,
	output logic [$clog2(TABLE_DEPTH)-1:0]     key_waddr,
	output logic [MAX_ORDER*KEY_W-1:0]         key_wdata,
	output logic                               cnt_re,
	output logic [$clog2(TABLE_DEPTH)-1:0]     cnt_raddr,
	input  logic [ngf_pkg::COUNT_W-1:0]        cnt_rdata,
	output logic                               cnt_we,
	output logic [$clog2(TABLE_DEPTH)-1:0]     cnt_waddr,
	output logic [ngf_pkg::COUNT_W-1:0]        cnt_wdata
);

	localparam int ORD_W = $clog2(MAX_ORDER + 1);
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	ngf_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]             scan_q;
	logic [CNT_W-1:0]             used_q;
	logic                         pend_s1;
	logic [IDX_W-1:0]             addr_s1;
	logic [MAX_ORDER*KEY_W-1:0]   gram_q;
	logic [ORD_W-1:0]             order_q;
	logic                         formed_q;
	logic                         last_q;
	logic [IDX_W-1:0]             idx_q;
	logic [ngf_pkg::COUNT_W-1:0]  cnt_q;
	logic                         ins_q;
	logic                         ovf_q;

	logic                         res_valid_q;
	logic                         res_formed_q;
	logic [ngf_pkg::IDX_OUT_W-1:0]  res_idx_q;
	logic [ngf_pkg::COUNT_W-1:0]    res_cnt_q;
	logic                         res_ins_q;
	logic                         res_ovf_q;
	logic [ngf_pkg::USED_OUT_W-1:0] res_used_q;

	logic                         accept;
	logic                         match;
	logic                         hit;
	logic                         scan_more;
	logic                         miss_done;
	logic                         room;
	logic                         load;
	logic                         rd_en;
	logic [ngf_pkg::COUNT_W-1:0]  cnt_next;

	assign accept    = tok.valid && tok.ready;
	assign scan_more = scan_q != used_q;
	assign hit       = pend_s1 && match;
	assign miss_done = !pend_s1 && !scan_more;
	assign room      = int'(used_q) < TABLE_DEPTH;
	assign load      = !res_valid_q || res.ready;
	assign cnt_next  = (cnt_rdata == ngf_pkg::COUNT_MAX) ? ngf_pkg::COUNT_MAX
		: cnt_rdata + ngf_pkg::COUNT_ONE;

	always_comb begin
		match = 1'b1;
		for (int k = 0; k < MAX_ORDER; k++) begin
			if (k < int'(order_q) &&
				key_rdata[k*KEY_W +: KEY_W] != gram_q[k*KEY_W +: KEY_W]) begin
				match = 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ngf_pkg::ST_IDLE: begin
				if (tok.valid) begin
					state_d = formed ? ngf_pkg::ST_SCAN : ngf_pkg::ST_DONE;
				end
			end
			ngf_pkg::ST_SCAN: begin
				if (hit) begin
					state_d = ngf_pkg::ST_WRITE;
				end else if (miss_done) begin
					state_d = room ? ngf_pkg::ST_WRITE : ngf_pkg::ST_DONE;
				end
			end
			ngf_pkg::ST_WRITE: begin
				state_d = ngf_pkg::ST_DONE;
			end
			ngf_pkg::ST_DONE: begin
				if (load) begin
					state_d = ngf_pkg::ST_IDLE;
				end
			end
			default: state_d = ngf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		tok.ready = 1'b0;
		rd_en     = 1'b0;
		key_we    = 1'b0;
		cnt_we    = 1'b0;
		unique case (state_q)
			ngf_pkg::ST_IDLE:  tok.ready = 1'b1;
			ngf_pkg::ST_SCAN:  rd_en     = scan_more && !hit;
			ngf_pkg::ST_WRITE: begin
				cnt_we = 1'b1;
				key_we = ins_q;
			end
			ngf_pkg::ST_DONE:  tok.ready = 1'b0;
			default:           tok.ready = 1'b0;
		endcase
	end

	assign win_ctl.shift = accept;
	assign win_ctl.clear = accept && tok.last_token;

	assign key_re    = rd_en;
	assign key_raddr = scan_q[IDX_W-1:0];
	assign cnt_re    = rd_en;
	assign cnt_raddr = scan_q[IDX_W-1:0];
	assign key_waddr = idx_q;
	assign key_wdata = gram_q;
	assign cnt_waddr = idx_q;
	assign cnt_wdata = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ngf_pkg::ST_IDLE;
			scan_q      <= '0;
			used_q      <= '0;
			pend_s1     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= rd_en;
			if (accept) begin
				scan_q <= '0;
			end else if (rd_en) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (state_q == ngf_pkg::ST_WRITE && ins_q) begin
				used_q <= used_q + CNT_W'(1);
			end else if (state_q == ngf_pkg::ST_DONE && load && last_q) begin
				used_q <= '0;
			end
			if (state_q == ngf_pkg::ST_DONE && load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= scan_q[IDX_W-1:0];
		if (accept) begin
			gram_q   <= gram;
			order_q  <= eff_order;
			formed_q <= formed;
			last_q   <= tok.last_token;
			idx_q    <= '0;
			cnt_q    <= '0;
			ins_q    <= 1'b0;
			ovf_q    <= 1'b0;
		end else if (state_q == ngf_pkg::ST_SCAN) begin
			if (hit) begin
				idx_q <= addr_s1;
				cnt_q <= cnt_next;
			end else if (miss_done) begin
				if (room) begin
					idx_q <= used_q[IDX_W-1:0];
					cnt_q <= ngf_pkg::COUNT_ONE;
					ins_q <= 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
		if (state_q == ngf_pkg::ST_DONE && load) begin
			res_formed_q <= formed_q;
			res_idx_q    <= ngf_pkg::IDX_OUT_W'(idx_q);
			res_cnt_q    <= cnt_q;
			res_ins_q    <= ins_q;
			res_ovf_q    <= ovf_q;
			res_used_q   <= ngf_pkg::USED_OUT_W'(used_q);
		end
	end

	assign res.valid          = res_valid_q;
	assign res.ngram_formed   = res_formed_q;
	assign res.entry_index    = res_idx_q;
	assign res.entry_count    = res_cnt_q;
	assign res.was_inserted   = res_ins_q;
	assign res.table_overflow = res_ovf_q;
	assign res.entries_in_use = res_used_q;

endmodule

### hw/rtl/ngram_frequency_table_core.sv
// N-gram frequency table top level: order register, token window, scan sequencer, memories.
// Depends on ngf_pkg, ngf_if, ngf_ram, ngf_window and ngf_scan.
// Per word: no key scan while the window fills; else the scan reads one entry per cycle up to
// the first match, whose count is updated, or past the last entry in use, when a miss appends
// or, if the table is full, overflows. One word in flight; an untaken result stalls the input.
// Reset clears window fill, entry count and order (to 2); memory above the count is never read.
module ngram_frequency_table_core #(
	parameter int TABLE_DEPTH = 256,
	parameter int MAX_ORDER   = 4,
	parameter int TOKEN_CHARS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	ngf_in_if.sink                     tok,
	ngf_out_if.source                  res,
	input  logic                       cfg_we,
	input  logic [ngf_pkg::CFG_W-1:0]  cfg_wdata
);

	localparam int KEY_W = 8 * TOKEN_CHARS;
	localparam int ORD_W = $clog2(MAX_ORDER + 1);
	localparam int IDX_W = $clog2(TABLE_DEPTH);

	logic [ngf_pkg::CFG_W-1:0]    order_q;
	logic [KEY_W-1:0]             key;
	logic [ORD_W-1:0]             eff_order;
	logic                         formed;
	logic [MAX_ORDER*KEY_W-1:0]   gram;
	ngf_pkg::win_ctl_t            win_ctl;

	logic                         key_re, key_we, cnt_re, cnt_we;
	logic [IDX_W-1:0]             key_raddr, key_waddr, cnt_raddr, cnt_waddr;
	logic [MAX_ORDER*KEY_W-1:0]   key_rdata, key_wdata;
	logic [ngf_pkg::COUNT_W-1:0]  cnt_rdata, cnt_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ngf_pkg::ORDER_RESET;
		end else if (cfg_we) begin
			order_q <= cfg_wdata;
		end
	end

	assign key = tok.token_key[KEY_W-1:0];

	ngf_window #(
		.MAX_ORDER (MAX_ORDER),
		.KEY_W     (KEY_W)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (win_ctl),
		.cfg_order (order_q),
		.key       (key),
		.eff_order (eff_order),
		.formed    (formed),
		.gram      (gram)
	);

	ngf_scan #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.MAX_ORDER   (MAX_ORDER),
		.KEY_W       (KEY_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (tok),
		.res       (res),
		.eff_order (eff_order),
		.formed    (formed),
		.gram      (gram),
		.win_ctl   (win_ctl),
		.key_re    (key_re),
		.key_raddr (key_raddr),
		.key_rdata (key_rdata),
		.key_we    (key_we),
		.key_waddr (key_waddr),
		.key_wdata (key_wdata),
		.cnt_re    (cnt_re),
		.cnt_raddr (cnt_raddr),
		.cnt_rdata (cnt_rdata),
		.cnt_we    (cnt_we),
		.cnt_waddr (cnt_waddr),
		.cnt_wdata (cnt_wdata)
	);

	ngf_ram #(
		.WIDTH (MAX_ORDER * KEY_W),
		.DEPTH (TABLE_DEPTH)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.re    (key_re),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	ngf_ram #(
		.WIDTH (ngf_pkg::COUNT_W),
		.DEPTH (TABLE_DEPTH)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

endmodule
